// File: sv/pcf_pkg.sv
// Shared types and codes for the palette cycle and fade engine.
// Used by every module of the block but pcf_ram; depends on nothing.
`timescale 1ns / 1ps

package pcf_pkg;

   // request type codes
   localparam logic [2:0] REQ_WRITE_CUR = 3'd0;
   localparam logic [2:0] REQ_WRITE_TGT = 3'd1;
   localparam logic [2:0] REQ_READ_CUR  = 3'd2;
   localparam logic [2:0] REQ_TICK      = 3'd3;
   localparam logic [2:0] REQ_CLEAR     = 3'd4;

   // fade goal codes; the last one is unused and fades nothing
   localparam logic [1:0] MODE_BLACK  = 2'd0;
   localparam logic [1:0] MODE_WHITE  = 2'd1;
   localparam logic [1:0] MODE_TARGET = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] entry_index;
      logic [5:0] red_in;
      logic [5:0] green_in;
      logic [5:0] blue_in;
      logic [1:0] fade_mode;
      logic [7:0] rand_value;
   } req_item_type;

   typedef struct packed {
      logic [5:0] red_out;
      logic [5:0] green_out;
      logic [5:0] blue_out;
      logic       fade_done;
   } rsp_item_type;

   // classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_WRITE_CUR,
      CMD_WRITE_TGT,
      CMD_READ,
      CMD_TICK,
      CMD_CLEAR,
      CMD_NOP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] index;
      logic [5:0] red;
      logic [5:0] green;
      logic [5:0] blue;
      logic [1:0] mode;
      logic [2:0] toggle_mask;
   } cmd_item_type;

   // one color channel of a command's write data
   function automatic logic [5:0] cmd_chan(input cmd_item_type cmd, input int c);
      logic [5:0] v;
      unique case (c)
         0:       v = cmd.red;
         1:       v = cmd.green;
         default: v = cmd.blue;
      endcase
      return v;
   endfunction

endpackage

// File: sv/palette_cycle_fade_engine_core.sv
// Top level of the palette cycle and fade engine.
// Depends on pcf_pkg, pcf_front, pcf_back and pcf_ram.
`timescale 1ns / 1ps

// Usage:
//  - Requests: drive req_item and raise start; the item is taken at a clock
//    edge where start is high and busy is low. busy rises only when the
//    two-entry command queue is full.
//  - Results: one per request, in order, on rsp_item for one cycle with
//    rsp_valid high. The receiver cannot stall; every result is final.
//  - Writes, clears and ticks that do not fade are answered from the queue head
//    through the result register; reads pass through the read state first.
//  - A fading tick sweeps entries 1..ENTRIES-1 through the palette stores at
//    one entry per cycle (one read and one write port per store), then drains;
//    no command is taken from the queue until it ends.
//  - Rotation moves no data: each channel of each palette keeps an offset
//    that is stepped at most once per tick.
//  - Reset: after reset falls a clearing pass zeroes every entry of both
//    palettes; items are queued meanwhile and run once it ends.
module palette_cycle_fade_engine_core #(
   parameter int ENTRIES   = 256,
   parameter int COLOR_MAX = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pcf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output pcf_pkg::rsp_item_type rsp_item
);
   import pcf_pkg::*;

   logic         head_valid;
   logic         head_pop;
   cmd_item_type head_cmd;

   // accept and classify
   pcf_front #(.ENTRIES(ENTRIES)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .head_valid(head_valid), .head_cmd(head_cmd),
      .head_pop(head_pop)
   );

   // carry out commands
   pcf_back #(.ENTRIES(ENTRIES), .COLOR_MAX(COLOR_MAX)) u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid),
      .head_cmd(head_cmd), .head_pop(head_pop), .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

endmodule

// File: sv/pcf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pcf_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/pcf_front.sv
// Front end: takes request items, classifies them into commands and holds
// them in a two-entry queue for the back end. Depends on pcf_pkg.
`timescale 1ns / 1ps

module pcf_front #(
   parameter int ENTRIES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pcf_pkg::req_item_type req_item,
   output logic                 head_valid,
   output pcf_pkg::cmd_item_type head_cmd,
   input  logic                 head_pop
);
   import pcf_pkg::*;

   cmd_item_type queue_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   cmd_item_type decoded;
   logic         in_range;
   logic         push;

   // classify the incoming item
   always_comb begin
      in_range            = 32'(req_item.entry_index) < ENTRIES;
      decoded.index       = req_item.entry_index;
      decoded.red         = req_item.red_in;
      decoded.green       = req_item.green_in;
      decoded.blue        = req_item.blue_in;
      decoded.mode        = req_item.fade_mode;
      decoded.toggle_mask = (req_item.rand_value < 8'd3) ?
                            (3'b001 << req_item.rand_value[1:0]) : 3'b000;
      unique case (req_item.req_type)
         REQ_WRITE_CUR: decoded.op = in_range ? CMD_WRITE_CUR : CMD_NOP;
         REQ_WRITE_TGT: decoded.op = in_range ? CMD_WRITE_TGT : CMD_NOP;
         REQ_READ_CUR:  decoded.op = in_range ? CMD_READ : CMD_NOP;
         REQ_TICK:      decoded.op = CMD_TICK;
         REQ_CLEAR:     decoded.op = CMD_CLEAR;
         default:       decoded.op = CMD_NOP;
      endcase
   end

   // queue pointers
   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (head_pop && head_valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(head_pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: sv/pcf_back.sv
// Back end: palette stores, rotation offsets, fade sweep and results.
// Depends on pcf_pkg and pcf_ram.
`timescale 1ns / 1ps

module pcf_back #(
   parameter int ENTRIES   = 256,
   parameter int COLOR_MAX = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  pcf_pkg::cmd_item_type head_cmd,
   output logic                  head_pop,
   output logic                  rsp_valid,
   output pcf_pkg::rsp_item_type rsp_item
);
   import pcf_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int M  = ENTRIES - 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // logical entry to physical address; entries 1..M rotate by offset
   function automatic logic [AW-1:0] map_addr(input logic [AW-1:0] x,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, x} + {1'b0, off};
      if (x == '0) begin
         return '0;
      end else if (sum >= (AW+1)'(ENTRIES)) begin
         return AW'(sum - (AW+1)'(M));
      end
      return AW'(sum);
   endfunction

   function automatic logic [AW-1:0] rot_off(input logic [AW-1:0] off,
                                             input logic backward);
      if (!backward) begin
         return (off == AW'(M - 1)) ? '0 : off + AW'(1);
      end
      return (off == '0) ? AW'(M - 1) : off - AW'(1);
   endfunction

   state_type    state_ff;
   cmd_item_type cmd_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] sweep_x_ff;
   logic          pipe_vld_ff;
   logic [AW-1:0] pipe_addr_ff [3];
   logic          all_ff;
   logic [2:0]    dir_ff;
   logic          flag_ff;
   logic [AW-1:0] cur_off_ff [3];
   logic [AW-1:0] tgt_off_ff [3];
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   logic          cur_we [3];
   logic [AW-1:0] cur_waddr [3];
   logic [5:0]    cur_wdata [3];
   logic [AW-1:0] cur_raddr [3];
   logic [5:0]    cur_rdata [3];
   logic          tgt_we [3];
   logic [AW-1:0] tgt_waddr [3];
   logic [5:0]    tgt_wdata [3];
   logic [AW-1:0] tgt_raddr [3];
   logic [5:0]    tgt_rdata [3];

   logic [5:0]    step_val [3];
   logic [2:0]    step_match;
   logic [AW-1:0] head_idx;

   cmd_item_type  tick_cmd;
   logic          fin_all;
   logic [2:0]    dir_in;
   logic          flag_in;
   logic [AW-1:0] cur_off_in [3];
   logic [AW-1:0] tgt_off_in [3];
   logic          rsp_valid_in;
   logic          pipe_vld_in;
   rsp_item_type  rsp_in;

   // per-channel stores, so each channel rotates on its own offset
   for (genvar c = 0; c < 3; c++) begin : g_chan
      pcf_ram #(.WIDTH(6), .DEPTH(ENTRIES)) u_cur (
         .clock(clock), .we(cur_we[c]), .waddr(cur_waddr[c]),
         .wdata(cur_wdata[c]), .raddr(cur_raddr[c]), .rdata(cur_rdata[c])
      );
      pcf_ram #(.WIDTH(6), .DEPTH(ENTRIES)) u_tgt (
         .clock(clock), .we(tgt_we[c]), .waddr(tgt_waddr[c]),
         .wdata(tgt_wdata[c]), .raddr(tgt_raddr[c]), .rdata(tgt_rdata[c])
      );
   end

   assign head_idx = AW'(head_cmd.index);
   assign head_pop = (state_ff == ST_IDLE) && head_valid;

   // fade step of one channel toward its goal
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         unique case (cmd_ff.mode)
            MODE_BLACK: begin
               step_match[c] = (cur_rdata[c] == 6'd0);
               step_val[c]   = step_match[c] ? cur_rdata[c] : cur_rdata[c] - 6'd1;
            end
            MODE_WHITE: begin
               step_match[c] = ({2'b00, cur_rdata[c]} >= 8'(COLOR_MAX));
               step_val[c]   = step_match[c] ? cur_rdata[c] : cur_rdata[c] + 6'd1;
            end
            MODE_TARGET: begin
               step_match[c] = (cur_rdata[c] == tgt_rdata[c]);
               if (cur_rdata[c] < tgt_rdata[c]) begin
                  step_val[c] = cur_rdata[c] + 6'd1;
               end else if (cur_rdata[c] > tgt_rdata[c]) begin
                  step_val[c] = cur_rdata[c] - 6'd1;
               end else begin
                  step_val[c] = cur_rdata[c];
               end
            end
            default: begin
               step_match[c] = 1'b1;
               step_val[c]   = cur_rdata[c];
            end
         endcase
      end
   end

   // store port steering
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cur_raddr[c] = (state_ff == ST_IDLE) ? map_addr(head_idx, cur_off_ff[c])
                                              : map_addr(sweep_x_ff, cur_off_ff[c]);
         tgt_raddr[c] = map_addr(sweep_x_ff, tgt_off_ff[c]);
         cur_we[c]    = 1'b0;
         cur_waddr[c] = map_addr(head_idx, cur_off_ff[c]);
         cur_wdata[c] = cmd_chan(head_cmd, c);
         tgt_we[c]    = 1'b0;
         tgt_waddr[c] = map_addr(head_idx, tgt_off_ff[c]);
         tgt_wdata[c] = cmd_chan(head_cmd, c);
         if (state_ff == ST_CLEAR) begin
            cur_we[c]    = 1'b1;
            cur_waddr[c] = clr_cnt_ff;
            cur_wdata[c] = 6'd0;
            tgt_we[c]    = 1'b1;
            tgt_waddr[c] = clr_cnt_ff;
            tgt_wdata[c] = 6'd0;
         end else if (pipe_vld_ff) begin
            cur_we[c]    = 1'b1;
            cur_waddr[c] = pipe_addr_ff[c];
            cur_wdata[c] = step_val[c];
         end else if (head_pop) begin
            cur_we[c] = (head_cmd.op == CMD_WRITE_CUR);
            tgt_we[c] = (head_cmd.op == CMD_WRITE_TGT);
         end
      end
   end

   // end of a tick: flag, direction toggle and rotation
   always_comb begin
      tick_cmd = (state_ff == ST_DRAIN) ? cmd_ff : head_cmd;
      fin_all  = (state_ff == ST_DRAIN) && all_ff && (&step_match);
      dir_in   = dir_ff;
      flag_in  = flag_ff;
      for (int c = 0; c < 3; c++) begin
         cur_off_in[c] = cur_off_ff[c];
         tgt_off_in[c] = tgt_off_ff[c];
      end
      if (!flag_ff) begin
         flag_in = fin_all;
         dir_in  = dir_ff ^ tick_cmd.toggle_mask;
         for (int c = 0; c < 3; c++) begin
            cur_off_in[c] = rot_off(cur_off_ff[c], dir_in[c]);
            if (tick_cmd.mode == MODE_TARGET) begin
               tgt_off_in[c] = rot_off(tgt_off_ff[c], dir_in[c]);
            end
         end
      end else if (tick_cmd.mode == MODE_TARGET) begin
         dir_in = dir_ff ^ tick_cmd.toggle_mask;
         for (int c = 0; c < 3; c++) begin
            cur_off_in[c] = rot_off(cur_off_ff[c], dir_in[c]);
         end
      end
   end

   // result and sweep-write strobes for the coming edge
   always_comb begin
      rsp_valid_in = 1'b0;
      pipe_vld_in  = (state_ff == ST_SWEEP);
      rsp_in       = '{default: '0, fade_done: flag_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head_cmd.op)
                  CMD_READ: begin
                     rsp_valid_in = 1'b0;
                  end
                  CMD_TICK: begin
                     if (flag_ff || head_cmd.mode == MODE_NONE) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.fade_done = flag_in;
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.fade_done = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.red_out   = cur_rdata[0];
            rsp_in.green_out = cur_rdata[1];
            rsp_in.blue_out  = cur_rdata[2];
         end
         ST_DRAIN: begin
            rsp_valid_in     = 1'b1;
            rsp_in.fade_done = flag_in;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // sequencer, state and results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pipe_vld_ff  <= 1'b0;
         dir_ff       <= 3'b000;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            cur_off_ff[c] <= '0;
            tgt_off_ff[c] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_ff       <= rsp_in;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == AW'(ENTRIES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (head_valid) begin
                  cmd_ff <= head_cmd;
                  unique case (head_cmd.op)
                     CMD_READ: begin
                        state_ff <= ST_READ;
                     end
                     CMD_TICK: begin
                        if (!flag_ff && head_cmd.mode != MODE_NONE) begin
                           state_ff   <= ST_SWEEP;
                           sweep_x_ff <= AW'(1);
                           all_ff     <= 1'b1;
                        end else begin
                           dir_ff     <= dir_in;
                           flag_ff    <= flag_in;
                           cur_off_ff <= cur_off_in;
                           tgt_off_ff <= tgt_off_in;
                        end
                     end
                     CMD_CLEAR: begin
                        flag_ff <= 1'b0;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               state_ff <= ST_IDLE;
            end
            ST_SWEEP: begin
               pipe_addr_ff <= cur_raddr;
               sweep_x_ff   <= sweep_x_ff + AW'(1);
               if (pipe_vld_ff) begin
                  all_ff <= all_ff && (&step_match);
               end
               if (sweep_x_ff == AW'(M)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               dir_ff     <= dir_in;
               flag_ff    <= flag_in;
               cur_off_ff <= cur_off_in;
               tgt_off_ff <= tgt_off_in;
               state_ff   <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   // sweep writes only follow a sweep read and never touch entry 0
   a_pipe_after_sweep: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> $past(state_ff == ST_SWEEP))
      else $error("sweep write without a sweep read");
   a_pipe_not_entry0: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> (pipe_addr_ff[0] != '0 && pipe_addr_ff[1] != '0 &&
                       pipe_addr_ff[2] != '0))
      else $error("fade sweep wrote entry 0");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP || state_ff == ST_CLEAR) |-> !head_pop)
      else $error("command taken while the stores are busy");
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      (cur_off_ff[0] < AW'(M) && tgt_off_ff[0] < AW'(M)))
      else $error("rotation offset out of range");
`endif

endmodule

// File: verif/palette_cycle_fade_checker.sv
// Result checker for the palette cycle and fade engine: predicts every answer
// from the accepted request items and compares. Depends on pcf_pkg.
`timescale 1ns / 1ps

module palette_cycle_fade_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  pcf_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  pcf_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending
);
   import pcf_pkg::*;

   localparam int NENT = 256;
   localparam int CMAX = 63;

   logic [5:0] cur_pal [NENT][3];
   logic [5:0] tgt_pal [NENT][3];
   logic [2:0] roll_dir;
   logic       faded;
   rsp_item_type answers [$];

   assign pending = answers.size();

   // rotate one channel of a palette over entries 1..NENT-1
   function automatic void rotate_pal(ref logic [5:0] pal [NENT][3], input int c,
                                      input logic back);
      logic [5:0] keep;
      if (!back) begin
         keep = pal[1][c];
         for (int x = 1; x < NENT - 1; x++) pal[x][c] = pal[x+1][c];
         pal[NENT-1][c] = keep;
      end else begin
         keep = pal[NENT-1][c];
         for (int x = NENT - 1; x > 1; x--) pal[x][c] = pal[x-1][c];
         pal[1][c] = keep;
      end
   endfunction

   // one tick: fade, toggle, rotate
   function automatic void tick_palette(input logic [1:0] mode, input logic [7:0] rnd);
      logic all_match;
      logic [5:0] goal;
      if (!faded) begin
         if (mode != MODE_NONE) begin
            all_match = 1'b1;
            for (int x = 1; x < NENT; x++)
               for (int c = 0; c < 3; c++) begin
                  goal = (mode == MODE_BLACK) ? 6'd0 :
                         (mode == MODE_WHITE) ? 6'(CMAX) : tgt_pal[x][c];
                  if (mode == MODE_WHITE && cur_pal[x][c] >= goal) continue;
                  if (cur_pal[x][c] < goal) begin
                     cur_pal[x][c]++; all_match = 1'b0;
                  end else if (cur_pal[x][c] > goal) begin
                     cur_pal[x][c]--; all_match = 1'b0;
                  end
               end
            if (all_match) faded = 1'b1;
         end
         if (rnd < 3) roll_dir[rnd] = ~roll_dir[rnd];
         for (int c = 0; c < 3; c++) rotate_pal(cur_pal, c, roll_dir[c]);
         if (mode == MODE_TARGET)
            for (int c = 0; c < 3; c++) rotate_pal(tgt_pal, c, roll_dir[c]);
      end else if (mode == MODE_TARGET) begin
         if (rnd < 3) roll_dir[rnd] = ~roll_dir[rnd];
         for (int c = 0; c < 3; c++) rotate_pal(cur_pal, c, roll_dir[c]);
      end
   endfunction

   // predict the answer to one request
   function automatic rsp_item_type predict_answer(input req_item_type it);
      rsp_item_type a;
      a = '0;
      case (it.req_type)
         REQ_WRITE_CUR: begin
            cur_pal[it.entry_index] = '{it.red_in, it.green_in, it.blue_in};
         end
         REQ_WRITE_TGT: begin
            tgt_pal[it.entry_index] = '{it.red_in, it.green_in, it.blue_in};
         end
         REQ_READ_CUR: begin
            a.red_out   = cur_pal[it.entry_index][0];
            a.green_out = cur_pal[it.entry_index][1];
            a.blue_out  = cur_pal[it.entry_index][2];
         end
         REQ_TICK:  tick_palette(it.fade_mode, it.rand_value);
         REQ_CLEAR: faded = 1'b0;
         default: ;
      endcase
      a.fade_done = faded;
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int x = 0; x < NENT; x++)
            for (int c = 0; c < 3; c++) begin
               cur_pal[x][c] = '0;
               tgt_pal[x][c] = '0;
            end
         roll_dir = '0;
         faded = 1'b0;
         fail_count <= 0;
         answers.delete();
      end else begin
         // check first so a same-edge request never races its own answer
         if (rsp_valid) begin
            if (answers.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (rsp_item !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p got %p", want, rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) answers.push_back(predict_answer(req_item));
      end
   end
endmodule

// File: verif/tb_palette_cycle_fade_engine_core.sv
// Testbench top for palette_cycle_fade_engine_core: drives request items and
// gives the verdict. Depends on pcf_pkg, that core and the checker.
`timescale 1ns / 1ps

module tb_palette_cycle_fade_engine_core;
   import pcf_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending;

   palette_cycle_fade_engine_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   palette_cycle_fade_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hand one item over and wait for it to be taken
   task automatic send_item(input req_item_type it, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(3) == 0) begin
         gap = $urandom_range(19, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic req_item_type make_item(input logic [2:0] op, input logic [7:0] idx,
                                              input logic [5:0] r, input logic [5:0] g,
                                              input logic [5:0] b, input logic [1:0] mode,
                                              input logic [7:0] rnd);
      req_item_type it;
      it = '{op, idx, r, g, b, mode, rnd};
      return it;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int pick;
      it = req_item_type'({$urandom, $urandom});
      pick = $urandom_range(99);
      // mostly writes, reads and ticks; ticks kept rarer since a fading one sweeps
      if (pick < 30)      it.req_type = REQ_WRITE_CUR;
      else if (pick < 50) it.req_type = REQ_WRITE_TGT;
      else if (pick < 75) it.req_type = REQ_READ_CUR;
      else if (pick < 88) it.req_type = REQ_TICK;
      else if (pick < 95) it.req_type = REQ_CLEAR;
      else                it.req_type = 3'($urandom_range(7, 5));
      if ($urandom_range(1)) it.rand_value = 8'($urandom_range(3));
      if ($urandom_range(3) != 0) it.fade_mode = 2'($urandom_range(2));
      if ($urandom_range(1)) it.entry_index = 8'($urandom_range(3));
      else if ($urandom_range(1)) it.entry_index = 8'($urandom_range(255, 252));
      return it;
   endfunction

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every request, unused mode and type, entry 0
      send_item(make_item(REQ_WRITE_CUR, 8'd0, 6'd63, 6'd63, 6'd63, MODE_BLACK, 8'd9), 0);
      send_item(make_item(REQ_WRITE_CUR, 8'd255, 6'd63, 6'd0, 6'd63, MODE_BLACK, 8'd9), 0);
      send_item(make_item(REQ_WRITE_CUR, 8'd1, 6'd1, 6'd2, 6'd3, MODE_BLACK, 8'd9), 0);
      send_item(make_item(REQ_WRITE_TGT, 8'd255, 6'd5, 6'd63, 6'd0, MODE_BLACK, 8'd9), 0);
      send_item(make_item(REQ_READ_CUR, 8'd0, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);
      send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_NONE, 8'd0), 0);
      send_item(make_item(REQ_READ_CUR, 8'd254, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);
      send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_WHITE, 8'd1), 0);
      send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_TARGET, 8'd2), 0);
      send_item(make_item(REQ_READ_CUR, 8'd255, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);
      send_item(make_item(REQ_READ_CUR, 8'd1, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);
      // fade to black until complete
      for (int k = 0; k < 66; k++)
         send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd200), 0);
      send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_TARGET, 8'd0), 0);
      send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_WHITE, 8'd0), 0);
      send_item(make_item(REQ_TICK, 8'd0, 6'd0, 6'd0, 6'd0, MODE_NONE, 8'd1), 0);
      send_item(make_item(3'd7, 8'd255, 6'd63, 6'd63, 6'd63, MODE_NONE, 8'd255), 0);
      send_item(make_item(3'd5, 8'd0, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);
      send_item(make_item(REQ_CLEAR, 8'd0, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);
      send_item(make_item(REQ_READ_CUR, 8'd0, 6'd0, 6'd0, 6'd0, MODE_BLACK, 8'd0), 0);

      // random part; the final stretch has no idle gaps
      for (int n = 0; n < 1900; n++)
         send_item(random_item(), n < 1700);
      start <= 1'b0;

      // let the checker record the last accepted item before draining
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end
endmodule
